// ===== sv/buffered_spi_master_core_assert.svh =====
// assertion helpers for the buffered spi master
// both sample on i_clk and stay quiet while i_rst_n is low
`ifndef BUFFERED_SPI_MASTER_CORE_ASSERT_SVH
`define BUFFERED_SPI_MASTER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bsm_pkg.sv =====
`timescale 1ns / 1ps

package bsm_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int WORD_W      = 16;
    localparam int DIV_W       = 8;
    localparam int BITS_W      = 5;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    // host operation codes
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_PUSH  = 2'd1;
    localparam logic [1:0] OP_POP   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SPI_MODE     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WORD16       = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_DIVIDE = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE       = 8'd3;

    typedef struct packed {
        logic push;
        logic pop;
    } t_queue_ctl;

endpackage

// ===== sv/bsm_ifs.sv =====
`timescale 1ns / 1ps

// host item channel
interface bsm_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  opcode;
    logic [bsm_pkg::WORD_W-1:0]  write_data;
    logic                        miso;

    modport source (output valid, output opcode, output write_data, output miso, input ready);
    modport sink   (input valid, input opcode, input write_data, input miso, output ready);
endinterface

// result channel
interface bsm_out_if;
    logic                        valid;
    logic                        ready;
    logic                        sclk;
    logic                        mosi;
    logic [bsm_pkg::WORD_W-1:0]  read_data;
    logic                        read_valid;
    logic                        push_accepted;
    logic [bsm_pkg::FILL_W-1:0]  tx_count;
    logic [bsm_pkg::FILL_W-1:0]  rx_count;
    logic                        busy_res;
    logic                        overflow;

    modport source (output valid, output sclk, output mosi, output read_data,
                    output read_valid, output push_accepted, output tx_count,
                    output rx_count, output busy_res, output overflow, input ready);
    modport sink   (input valid, input sclk, input mosi, input read_data,
                    input read_valid, input push_accepted, input tx_count,
                    input rx_count, input busy_res, input overflow, output ready);
endinterface

// configuration write channel
interface bsm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bsm_pkg::CFG_INDEX_W-1:0]  index;
    logic [bsm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/bsm_queue.sv =====
`timescale 1ns / 1ps

// ring queue, oldest entry always visible at the head
module bsm_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bsm_pkg::t_queue_ctl           i_ctl,
    input  logic [bsm_pkg::WORD_W-1:0]    i_push_data,
    output logic [bsm_pkg::WORD_W-1:0]    o_head_data,
    output logic [bsm_pkg::FILL_W-1:0]    o_fill
);

    logic [bsm_pkg::WORD_W-1:0] r_mem [bsm_pkg::QUEUE_DEPTH];
    logic [bsm_pkg::PTR_W-1:0]  r_head, n_head;
    logic [bsm_pkg::PTR_W-1:0]  r_tail, n_tail;
    logic [bsm_pkg::FILL_W-1:0] r_fill, n_fill;

    localparam logic [bsm_pkg::PTR_W-1:0] LAST_PTR = bsm_pkg::PTR_W'(bsm_pkg::QUEUE_DEPTH - 1);

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (i_ctl.pop) begin
            n_head = (r_head == LAST_PTR) ? '0 : r_head + 1'b1;
        end
        if (i_ctl.push) begin
            n_tail = (r_tail == LAST_PTR) ? '0 : r_tail + 1'b1;
        end
        n_fill = r_fill + bsm_pkg::FILL_W'(i_ctl.push) - bsm_pkg::FILL_W'(i_ctl.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_push_data;
        end
    end

    assign o_head_data = r_mem[r_head];
    assign o_fill      = r_fill;

endmodule

// ===== sv/buffered_spi_master_core.sv =====
`timescale 1ns / 1ps
// buffered spi master: one host item per clock while results are taken, one result per item
// an item is held in the input stage, then its result in the result register
// throughput: one item every cycle unless the result channel stalls; the next state is combinational
// reset: synchronous, active low; clears config to defaults, queue counts, shifter and flags
// queue storage is not cleared, only entries covered by the fill counts are ever read

module buffered_spi_master_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bsm_in_if.sink     i_in,
    bsm_out_if.source  o_out,
    bsm_cfg_if.sink    i_cfg
);

`include "buffered_spi_master_core_assert.svh"

    // configuration registers
    logic [1:0]                      r_spi_mode;
    logic                            r_word16;
    logic [bsm_pkg::DIV_W-1:0]       r_clock_divide;
    logic                            r_enable;

    // input stage
    logic                            r_in_valid;
    logic [1:0]                      r_in_opcode;
    logic [bsm_pkg::WORD_W-1:0]      r_in_write_data;
    logic                            r_in_miso;

    // shifter state
    logic [bsm_pkg::WORD_W-1:0]      r_shift, n_shift;
    logic [bsm_pkg::BITS_W-1:0]      r_bits, n_bits;
    logic [bsm_pkg::DIV_W-1:0]       r_div, n_div;
    logic                            r_clock_level, n_clock_level;
    logic                            r_mosi, n_mosi;
    logic                            r_busy, n_busy;
    logic                            r_wide, n_wide;
    logic                            r_overflow, n_overflow;

    // result register
    logic                            r_out_valid;
    logic                            r_out_sclk;
    logic                            r_out_mosi;
    logic [bsm_pkg::WORD_W-1:0]      r_out_read_data;
    logic                            r_out_read_valid;
    logic                            r_out_push_accepted;
    logic [bsm_pkg::FILL_W-1:0]      r_out_tx_count;
    logic [bsm_pkg::FILL_W-1:0]      r_out_rx_count;
    logic                            r_out_busy;
    logic                            r_out_overflow;

    // datapath
    logic                            w_adv;
    logic                            w_push_ok, w_pop_ok, w_tx_take;
    logic                            w_finish, w_rx_push, w_drop;
    logic                            w_leading, w_sample;
    logic                            w_idle_lvl, w_cke;
    logic [bsm_pkg::FILL_W-1:0]      w_tx_fill, w_rx_fill;
    logic [bsm_pkg::FILL_W-1:0]      w_tx_fill_pushed, w_rx_fill_popped;
    logic [bsm_pkg::FILL_W-1:0]      n_tx_fill, n_rx_fill;
    logic [bsm_pkg::WORD_W-1:0]      w_tx_head, w_rx_head, w_tx_word;
    logic [bsm_pkg::DIV_W-1:0]       w_div_eff;
    logic [bsm_pkg::DIV_W:0]         w_div_inc;
    bsm_pkg::t_queue_ctl             w_tx_ctl, w_rx_ctl;

    localparam logic [bsm_pkg::FILL_W-1:0] FULL_FILL = bsm_pkg::FILL_W'(bsm_pkg::QUEUE_DEPTH);

    // ---------------------------------------------------------------
    // configuration port, always ready; the user is to write it only while idle, the block does not enforce this
    // ---------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spi_mode     <= 2'd0;
            r_word16       <= 1'b0;
            r_clock_divide <= bsm_pkg::DIV_W'(1);
            r_enable       <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bsm_pkg::CFG_SPI_MODE:     r_spi_mode     <= i_cfg.data[1:0];
                bsm_pkg::CFG_WORD16:       r_word16       <= i_cfg.data[0];
                bsm_pkg::CFG_CLOCK_DIVIDE: r_clock_divide <= i_cfg.data;
                bsm_pkg::CFG_ENABLE:       r_enable       <= i_cfg.data[0];
                default: ; // unknown index, ignored
            endcase
        end
    end

    // ---------------------------------------------------------------
    // handshake: the input stage advances when the result register is
    // free or being emptied in the same cycle
    // ---------------------------------------------------------------
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // payload of the input stage needs no reset
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_opcode     <= i_in.opcode;
            r_in_write_data <= i_in.write_data;
            r_in_miso       <= i_in.miso;
        end
    end

    // ---------------------------------------------------------------
    // host operation first: push into transmit queue or pop receive queue
    // ---------------------------------------------------------------
    assign w_push_ok        = (r_in_opcode == bsm_pkg::OP_PUSH) && (w_tx_fill != FULL_FILL);
    assign w_pop_ok         = (r_in_opcode == bsm_pkg::OP_POP) && (w_rx_fill != '0);
    assign w_tx_fill_pushed = w_tx_fill + bsm_pkg::FILL_W'(w_push_ok);
    assign w_rx_fill_popped = w_rx_fill - bsm_pkg::FILL_W'(w_pop_ok);

    // an idle shifter may take the word pushed on this very tick
    assign w_tx_take = !r_busy && r_enable && (w_tx_fill_pushed != '0);
    assign w_tx_word = (w_tx_fill == '0) ? r_in_write_data : w_tx_head;

    // ---------------------------------------------------------------
    // shifter: serial clock divider and full duplex shift register
    // ---------------------------------------------------------------
    assign w_idle_lvl = r_spi_mode[1];
    assign w_cke      = r_spi_mode[0];
    assign w_div_eff  = (r_clock_divide == '0) ? bsm_pkg::DIV_W'(1) : r_clock_divide;
    assign w_div_inc  = {1'b0, r_div} + (bsm_pkg::DIV_W + 1)'(1);

    always_comb begin
        n_shift       = r_shift;
        n_bits        = r_bits;
        n_div         = r_div;
        n_clock_level = r_clock_level;
        n_mosi        = r_mosi;
        n_busy        = r_busy;
        n_wide        = r_wide;
        w_leading     = 1'b0;
        w_sample      = 1'b0;
        w_finish      = 1'b0;
        if (!r_busy) begin
            // idle: clock sits at the mode's idle level, mosi holds unless a word starts with cke set
            n_clock_level = w_idle_lvl;
            if (w_tx_take) begin
                n_wide  = r_word16;
                n_shift = r_word16 ? w_tx_word : {8'h00, w_tx_word[7:0]};
                n_bits  = r_word16 ? bsm_pkg::BITS_W'(16) : bsm_pkg::BITS_W'(8);
                n_div   = '0;
                n_busy  = 1'b1;
                if (w_cke) begin
                    // cke set: the first bit is presented before the leading edge
                    n_mosi = r_word16 ? w_tx_word[15] : w_tx_word[7];
                end
            end
        end else if (w_div_inc >= {1'b0, w_div_eff}) begin
            // half period over: toggle the serial clock
            n_div         = '0;
            n_clock_level = !r_clock_level;
            w_leading     = (n_clock_level != w_idle_lvl);
            w_sample      = w_leading ? w_cke : !w_cke;
            if (w_sample) begin
                if (r_bits != '0) begin
                    n_shift = r_wide ? {r_shift[14:0], r_in_miso}
                                     : {8'h00, r_shift[6:0], r_in_miso};
                    n_bits  = r_bits - 1'b1;
                end
            end else if (r_bits != '0) begin
                n_mosi = r_wide ? r_shift[15] : r_shift[7];
            end
            // word ends on a trailing edge once every bit is sampled
            if (!w_leading && (n_bits == '0)) begin
                n_busy   = 1'b0;
                w_finish = 1'b1;
            end
        end else begin
            n_div = w_div_inc[bsm_pkg::DIV_W-1:0];
        end
    end

    // finished word goes to the receive queue, or is dropped when full
    assign w_rx_push  = w_finish && (w_rx_fill_popped != FULL_FILL);
    assign w_drop     = w_finish && !w_rx_push;
    // a drop on the same tick wins over a clear
    assign n_overflow = (r_overflow && (r_in_opcode != bsm_pkg::OP_CLEAR)) || w_drop;

    assign n_tx_fill = w_tx_fill_pushed - bsm_pkg::FILL_W'(w_tx_take);
    assign n_rx_fill = w_rx_fill_popped + bsm_pkg::FILL_W'(w_rx_push);

    // queue controls only move on an advancing item
    assign w_tx_ctl.push = w_adv && w_push_ok;
    assign w_tx_ctl.pop  = w_adv && w_tx_take;
    assign w_rx_ctl.push = w_adv && w_rx_push;
    assign w_rx_ctl.pop  = w_adv && w_pop_ok;

    bsm_queue u_tx_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_tx_ctl),
        .i_push_data (r_in_write_data),
        .o_head_data (w_tx_head),
        .o_fill      (w_tx_fill)
    );

    bsm_queue u_rx_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_rx_ctl),
        .i_push_data (n_shift),
        .o_head_data (w_rx_head),
        .o_fill      (w_rx_fill)
    );

    // shifter state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift       <= '0;
            r_bits        <= '0;
            r_div         <= '0;
            r_clock_level <= 1'b0;
            r_mosi        <= 1'b0;
            r_busy        <= 1'b0;
            r_wide        <= 1'b0;
            r_overflow    <= 1'b0;
        end else if (w_adv) begin
            r_shift       <= n_shift;
            r_bits        <= n_bits;
            r_div         <= n_div;
            r_clock_level <= n_clock_level;
            r_mosi        <= n_mosi;
            r_busy        <= n_busy;
            r_wide        <= n_wide;
            r_overflow    <= n_overflow;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_sclk          <= n_clock_level;
            r_out_mosi          <= n_mosi;
            r_out_read_data     <= w_pop_ok ? w_rx_head : '0;
            r_out_read_valid    <= w_pop_ok;
            r_out_push_accepted <= w_push_ok;
            r_out_tx_count      <= n_tx_fill;
            r_out_rx_count      <= n_rx_fill;
            r_out_busy          <= n_busy;
            r_out_overflow      <= n_overflow;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.sclk          = r_out_sclk;
    assign o_out.mosi          = r_out_mosi;
    assign o_out.read_data     = r_out_read_data;
    assign o_out.read_valid    = r_out_read_valid;
    assign o_out.push_accepted = r_out_push_accepted;
    assign o_out.tx_count      = r_out_tx_count;
    assign o_out.rx_count      = r_out_rx_count;
    assign o_out.busy_res      = r_out_busy;
    assign o_out.overflow      = r_out_overflow;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `BSM_ASSERT_NEXT(a_tx_fill_hold, !w_adv, $stable(w_tx_fill), "tx fill moved without a transfer")
    `BSM_ASSERT_NOW(a_rx_fill_bound, 1'b1, w_rx_fill <= FULL_FILL, "rx fill beyond queue depth")
    `BSM_ASSERT_NOW(a_byte_clean, r_busy && !r_wide, r_shift[15:8] == 8'h00, "byte word has high bits")
    `BSM_ASSERT_NOW(a_single_op, r_out_valid, !(r_out_read_valid && r_out_push_accepted), "pop and push in one result")

endmodule

// ===== tb/sv/tb_buffered_spi_master_core.sv =====
`timescale 1ns / 1ps

module tb_buffered_spi_master_core;

    // one result as the block presents it, fields in port order
    typedef struct packed {
        logic                       sclk;
        logic                       mosi;
        logic [bsm_pkg::WORD_W-1:0] read_data;
        logic                       read_valid;
        logic                       push_accepted;
        logic [bsm_pkg::FILL_W-1:0] tx_count;
        logic [bsm_pkg::FILL_W-1:0] rx_count;
        logic                       busy;
        logic                       overflow;
    } t_spi_result;

    // one host item: a clock tick plus an optional host operation
    typedef struct packed {
        logic [1:0]                 op;
        logic [bsm_pkg::WORD_W-1:0] wdata;
        logic                       miso;
    } t_host_item;

    // operation mixes for the random phases
    typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} t_op_mix;

    logic i_clk;
    logic i_rst_n;

    bsm_in_if  host_ch ();
    bsm_out_if result_ch ();
    bsm_cfg_if cfg_ch ();

    buffered_spi_master_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (host_ch),
        .o_out   (result_ch),
        .i_cfg   (cfg_ch)
    );

    // items waiting for the driver, and results predicted but not yet seen
    t_host_item  host_items[$];
    t_spi_result predicted_results[$];

    int items_queued = 0;
    int items_taken  = 0;
    int mismatches   = 0;

    // random idling on both channels, switched off for the last phases
    bit idling     = 1'b1;
    int gap_left   = 0;
    int stall_left = 0;

    t_host_item  next_item;
    t_spi_result seen;
    t_spi_result want;

    // shadow copy of the configuration registers
    logic [1:0]                cur_mode;
    logic                      cur_word16;
    logic [bsm_pkg::DIV_W-1:0] cur_divide;
    logic                      cur_enable;

    // shadow copy of the queues and the shifter
    logic [bsm_pkg::WORD_W-1:0] tx_mem [bsm_pkg::QUEUE_DEPTH];
    logic [bsm_pkg::PTR_W-1:0]  tx_head;
    logic [bsm_pkg::FILL_W-1:0] tx_fill;
    logic [bsm_pkg::WORD_W-1:0] rx_mem [bsm_pkg::QUEUE_DEPTH];
    logic [bsm_pkg::PTR_W-1:0]  rx_tail;
    logic [bsm_pkg::FILL_W-1:0] rx_fill;
    logic [bsm_pkg::WORD_W-1:0] shreg;
    logic [bsm_pkg::BITS_W-1:0] bits_left;
    logic [bsm_pkg::DIV_W-1:0]  div_cnt;
    logic                       sclk_lvl;
    logic                       ovf_flag;
    logic                       shifting;
    logic                       wide_word;
    logic                       mosi_lvl;

    // advances the shadow state for one host item and returns the result it gives
    function automatic t_spi_result spi_tick(input logic [1:0] op,
                                             input logic [bsm_pkg::WORD_W-1:0] wd,
                                             input logic miso);
        t_spi_result                r;
        logic                       idle_lvl;
        logic                       cke;
        logic                       leading;
        logic                       sample;
        logic [bsm_pkg::WORD_W-1:0] mask;
        logic [bsm_pkg::DIV_W-1:0]  div;
        logic [bsm_pkg::PTR_W-1:0]  slot;
        r        = '0;
        idle_lvl = cur_mode[1];
        cke      = cur_mode[0];

        // host operation first
        case (op)
            bsm_pkg::OP_PUSH: begin
                if (tx_fill < bsm_pkg::QUEUE_DEPTH) begin
                    slot         = tx_head + tx_fill[bsm_pkg::PTR_W-1:0];
                    tx_mem[slot] = wd;
                    tx_fill++;
                    r.push_accepted = 1'b1;
                end
            end
            bsm_pkg::OP_POP: begin
                if (rx_fill != 0) begin
                    // oldest entry sits rx_fill places behind the write pointer
                    slot        = rx_tail - rx_fill[bsm_pkg::PTR_W-1:0];
                    r.read_data = rx_mem[slot];
                    rx_fill--;
                    r.read_valid = 1'b1;
                end
            end
            bsm_pkg::OP_CLEAR: ovf_flag = 1'b0;
            default: ;
        endcase

        // then the shifter advances
        if (!shifting) begin
            sclk_lvl = idle_lvl;
            if (cur_enable && tx_fill != 0) begin
                // width is latched here and kept for the whole frame
                wide_word = cur_word16;
                mask      = wide_word ? 16'hFFFF : 16'h00FF;
                shreg     = tx_mem[tx_head] & mask;
                tx_head++;
                tx_fill--;
                bits_left = wide_word ? 5'd16 : 5'd8;
                div_cnt   = '0;
                shifting  = 1'b1;
                if (cke)
                    mosi_lvl = wide_word ? shreg[15] : shreg[7];
            end
        end else begin
            mask = wide_word ? 16'hFFFF : 16'h00FF;
            // a zero divider behaves as one
            div  = (cur_divide == 0) ? 8'd1 : cur_divide;
            div_cnt++;
            if (div_cnt >= div) begin
                div_cnt  = '0;
                sclk_lvl = ~sclk_lvl;
                leading  = (sclk_lvl != idle_lvl);
                sample   = leading ? cke : ~cke;
                if (sample) begin
                    if (bits_left != 0) begin
                        shreg = {shreg[bsm_pkg::WORD_W-2:0], miso} & mask;
                        bits_left--;
                    end
                end else if (bits_left != 0) begin
                    mosi_lvl = wide_word ? shreg[15] : shreg[7];
                end
                // frame ends on a trailing edge once every bit is in
                if (!leading && bits_left == 0) begin
                    shifting = 1'b0;
                    if (rx_fill < bsm_pkg::QUEUE_DEPTH) begin
                        rx_mem[rx_tail] = shreg & mask;
                        rx_tail++;
                        rx_fill++;
                    end else begin
                        ovf_flag = 1'b1;
                    end
                end
            end
        end

        r.sclk     = sclk_lvl;
        r.mosi     = mosi_lvl;
        r.tx_count = tx_fill;
        r.rx_count = rx_fill;
        r.busy     = shifting;
        r.overflow = ovf_flag;
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: presents queued host items, holding each until its transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            host_ch.valid      <= 1'b0;
            host_ch.opcode     <= bsm_pkg::OP_NONE;
            host_ch.write_data <= '0;
            host_ch.miso       <= 1'b0;
        end else if (!host_ch.valid || host_ch.ready) begin
            if (idling && gap_left == 0 && $urandom_range(0, 7) == 0)
                gap_left = $urandom_range(1, 10);
            if (idling && gap_left > 0) begin
                gap_left--;
                host_ch.valid <= 1'b0;
            end else if (host_items.size() > 0) begin
                next_item = host_items.pop_front();
                host_ch.valid      <= 1'b1;
                host_ch.opcode     <= next_item.op;
                host_ch.write_data <= next_item.wdata;
                host_ch.miso       <= next_item.miso;
            end else begin
                host_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result transfer against the oldest prediction,
    // then predicts for any host transfer and tracks register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                seen = {result_ch.sclk, result_ch.mosi, result_ch.read_data,
                        result_ch.read_valid, result_ch.push_accepted,
                        result_ch.tx_count, result_ch.rx_count,
                        result_ch.busy_res, result_ch.overflow};
                if (predicted_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with nothing predicted: %h", seen);
                end else begin
                    want = predicted_results.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected sclk=%0b mosi=%0b data=%h rvalid=%0b",
                                     want.sclk, want.mosi, want.read_data, want.read_valid);
                            $display("  pushed=%0b tx=%0d rx=%0d busy=%0b ovf=%0b",
                                     want.push_accepted, want.tx_count, want.rx_count,
                                     want.busy, want.overflow);
                            $display("  actual sclk=%0b mosi=%0b data=%h rvalid=%0b",
                                     seen.sclk, seen.mosi, seen.read_data, seen.read_valid);
                            $display("  pushed=%0b tx=%0d rx=%0d busy=%0b ovf=%0b",
                                     seen.push_accepted, seen.tx_count, seen.rx_count,
                                     seen.busy, seen.overflow);
                        end
                    end
                end
            end

            // register writes; unknown indexes leave everything alone
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    bsm_pkg::CFG_SPI_MODE:     cur_mode   = cfg_ch.data[1:0];
                    bsm_pkg::CFG_WORD16:       cur_word16 = cfg_ch.data[0];
                    bsm_pkg::CFG_CLOCK_DIVIDE: cur_divide = cfg_ch.data;
                    bsm_pkg::CFG_ENABLE:       cur_enable = cfg_ch.data[0];
                    default: ;
                endcase
            end

            if (host_ch.valid && host_ch.ready) begin
                predicted_results.push_back(spi_tick(host_ch.opcode, host_ch.write_data,
                                                     host_ch.miso));
                items_taken++;
            end

            // receiver back-pressure in random bursts
            if (idling && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 10);
            if (idling && stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic add_item(input logic [1:0] op, input logic [bsm_pkg::WORD_W-1:0] wd,
                            input logic miso);
        host_items.push_back('{op: op, wdata: wd, miso: miso});
        items_queued++;
    endtask

    // waits until every queued item is taken and its result checked
    task automatic drain_results();
        while (items_taken != items_queued || predicted_results.size() != 0)
            @(negedge i_clk);
        // pipeline is two deep, the extra wait lets it settle
        repeat (4) @(negedge i_clk);
    endtask

    // one register write; entered at a rising edge, leaves valid high
    task automatic write_reg(input logic [bsm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bsm_pkg::CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
    endtask

    // writes all four registers, unused data bits filled with noise,
    // optionally followed by a write to an index that does not exist
    task automatic configure(input logic [1:0] mode, input logic w16,
                             input logic [bsm_pkg::DIV_W-1:0] div, input logic en,
                             input bit odd_index);
        logic [bsm_pkg::CFG_DATA_W-1:0] junk;
        @(posedge i_clk);
        junk = bsm_pkg::CFG_DATA_W'($urandom);
        write_reg(bsm_pkg::CFG_SPI_MODE, {junk[7:2], mode});
        junk = bsm_pkg::CFG_DATA_W'($urandom);
        write_reg(bsm_pkg::CFG_WORD16, {junk[7:1], w16});
        write_reg(bsm_pkg::CFG_CLOCK_DIVIDE, div);
        junk = bsm_pkg::CFG_DATA_W'($urandom);
        write_reg(bsm_pkg::CFG_ENABLE, {junk[7:1], en});
        if (odd_index)
            write_reg(bsm_pkg::CFG_INDEX_W'($urandom_range(bsm_pkg::CFG_ENABLE + 1, 255)),
                      bsm_pkg::CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // random items with random content in the chosen operation mix
    task automatic gen_items(input int count, input t_op_mix mix);
        int         pick;
        logic [1:0] op;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            case (mix)
                MIX_FILL:  op = (pick < 45) ? bsm_pkg::OP_NONE :
                                (pick < 65) ? bsm_pkg::OP_PUSH : bsm_pkg::OP_CLEAR;
                MIX_DRAIN: op = (pick < 50) ? bsm_pkg::OP_NONE :
                                (pick < 55) ? bsm_pkg::OP_PUSH :
                                (pick < 93) ? bsm_pkg::OP_POP  : bsm_pkg::OP_CLEAR;
                default:   op = (pick < 55) ? bsm_pkg::OP_NONE :
                                (pick < 78) ? bsm_pkg::OP_PUSH :
                                (pick < 95) ? bsm_pkg::OP_POP  : bsm_pkg::OP_CLEAR;
            endcase
            add_item(op, bsm_pkg::WORD_W'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    // stimulus
    initial begin
        i_rst_n      <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= bsm_pkg::CFG_SPI_MODE;
        cfg_ch.data  <= '0;

        // shadow state after reset
        cur_mode   = 2'd0;
        cur_word16 = 1'b0;
        cur_divide = 8'd1;
        cur_enable = 1'b0;
        tx_head    = '0;
        tx_fill    = '0;
        rx_tail    = '0;
        rx_fill    = '0;
        shreg      = '0;
        bits_left  = '0;
        div_cnt    = '0;
        sclk_lvl   = 1'b0;
        ovf_flag   = 1'b0;
        shifting   = 1'b0;
        wide_word  = 1'b0;
        mosi_lvl   = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // shifter still disabled: pop from an empty queue, clear, extreme words
        add_item(bsm_pkg::OP_POP,   16'h0000, 1'b0);
        add_item(bsm_pkg::OP_CLEAR, 16'hFFFF, 1'b1);
        add_item(bsm_pkg::OP_PUSH,  16'hFFFF, 1'b0);
        add_item(bsm_pkg::OP_PUSH,  16'h0000, 1'b1);
        add_item(bsm_pkg::OP_PUSH,  16'h8001, 1'b0);
        add_item(bsm_pkg::OP_PUSH,  16'h7FFE, 1'b1);
        add_item(bsm_pkg::OP_NONE,  16'h0000, 1'b0);
        add_item(bsm_pkg::OP_POP,   16'hFFFF, 1'b1);
        drain_results();

        // zero divider, 16-bit frames, mode 0, plus a write to a missing register
        configure(2'd0, 1'b1, 8'd0, 1'b1, 1'b1);
        for (int n = 0; n < 14; n++)
            add_item(bsm_pkg::OP_NONE, bsm_pkg::WORD_W'($urandom), n[1]);
        add_item(bsm_pkg::OP_PUSH, 16'h5A5A, 1'b1);
        drain_results();

        // random phases; the first ones start while a frame is still in flight,
        // so mode and width change mid-frame
        for (int ph = 0; ph < 11; ph++) begin
            if (ph >= 9)
                idling = 1'b0;
            case (ph)
                0: begin
                    configure(2'd3, 1'b0, 8'd1, 1'b1, 1'b0);
                    gen_items(60, MIX_BALANCED);
                end
                1: begin
                    // byte frames at full speed with no pops: receive queue overflows
                    configure(2'd1, 1'b0, 8'd1, 1'b1, 1'b1);
                    gen_items(400, MIX_FILL);
                end
                2: begin
                    configure(2'd2, 1'b1, 8'd2, 1'b1, 1'b0);
                    gen_items(90, MIX_DRAIN);
                end
                3: begin
                    // slowest divider, kept short
                    configure(2'd0, 1'b0, 8'd255, 1'b1, 1'b0);
                    gen_items(100, MIX_BALANCED);
                end
                4: begin
                    // shifter switched off part-way through a frame
                    configure(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 8'd1,
                              1'b0, 1'b0);
                    gen_items(40, MIX_BALANCED);
                end
                default: begin
                    configure(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              bsm_pkg::DIV_W'($urandom_range(1, 4)), 1'b1,
                              1'($urandom_range(0, 1)));
                    gen_items(int'($urandom_range(20, 40)), t_op_mix'($urandom_range(0, 2)));
                end
            endcase
            drain_results();
        end

        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== buffered_spi_master_core.f =====
+incdir+sv
sv/bsm_pkg.sv
sv/bsm_ifs.sv
sv/bsm_queue.sv
sv/buffered_spi_master_core.sv
tb/sv/tb_buffered_spi_master_core.sv
